>>> design/rpg_pkg.sv
// ----------------------------------------------------------------------------
// rpg_pkg: shared types and constants of the ring point generator
// Register indexes, mode codes, CORDIC table and the rounding helper.
// ----------------------------------------------------------------------------
package rpg_pkg;

   // default parameter values
   localparam int PHASE_BITS_DEF    = 32;
   localparam int CORDIC_STAGES_DEF = 24;

   // field widths
   localparam int IDX_W   = 16;
   localparam int RAD_W   = 24;
   localparam int FREQ_W  = 16;
   localparam int XY_W    = 26;
   localparam int Z_W     = 25;
   localparam int ANGLE_W = 32;
   localparam int TRIG_W  = 32;
   localparam int CXY_W   = 34;
   localparam int CZ_W    = 33;
   localparam int CSR_A_W = 3;

   localparam logic signed [TRIG_W-1:0] TRIG_ONE = 32'sh4000_0000;
   localparam logic signed [CXY_W-1:0] TRIG_ONE_X = 34'sh0_4000_0000;
   localparam logic signed [CXY_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

   // arctangent of 2^-i in units of a quarter turn / 2^30
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};

   // modes
   localparam logic [1:0] MODE_CIRCLE = 2'd0;
   localparam logic [1:0] MODE_SINE   = 2'd1;
   localparam logic [1:0] MODE_SPIRAL = 2'd2;

   // quadrants of the angle
   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;

   // register indexes
   typedef enum logic [CSR_A_W-1:0] {
      REG_MODE       = 3'd0,
      REG_NODE_COUNT = 3'd1,
      REG_MAIN_RAD   = 3'd2,
      REG_WAVE_FREQ  = 3'd3,
      REG_MINOR_RAD  = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [IDX_W-1:0]  node_count;
      logic [RAD_W-1:0]  main_radius;
      logic [FREQ_W-1:0] wave_frequency;
      logic [RAD_W-1:0]  minor_radius;
   } cfg_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_v;
      logic signed [TRIG_W-1:0] sin_v;
   } trig_type;

   // product of a length and a Q2.30 factor, rounded half up
   function automatic logic signed [63:0] round_q30(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + 64'sd536870912;
      return s >>> 30;
   endfunction

endpackage

>>> design/rpg_div.sv
// ----------------------------------------------------------------------------
// rpg_div: pipelined restoring divider
// Turns a node index into the phase floor(index * 2^PHASE_BITS / node_count).
// ----------------------------------------------------------------------------
module rpg_div #(
   parameter int PHASE_BITS = rpg_pkg::PHASE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [rpg_pkg::IDX_W-1:0]  in_index,
   input  logic [rpg_pkg::IDX_W-1:0]  node_count,
   output logic                       out_valid,
   output logic                       out_bad,
   output logic [PHASE_BITS-1:0]      out_phase
);
   import rpg_pkg::*;

   logic                  v_ff   [PHASE_BITS+1];
   logic                  bad_ff [PHASE_BITS+1];
   logic [IDX_W:0]        rem_ff [PHASE_BITS+1];
   logic [PHASE_BITS-1:0] quo_ff [PHASE_BITS+1];
   logic                  bad_in;

   // range check and first stage
   assign bad_in = (node_count == '0) || (in_index >= node_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bad_ff[0] <= bad_in;
         rem_ff[0] <= bad_in ? '0 : {1'b0, in_index};
         quo_ff[0] <= '0;
      end
   end

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < PHASE_BITS; k++) begin : g_step
      logic [IDX_W+1:0] shifted;
      logic [IDX_W+1:0] diff;
      logic             ge;

      always_comb begin
         shifted = {rem_ff[k], 1'b0};
         diff    = shifted - {2'b00, node_count};
         ge      = shifted >= {2'b00, node_count};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            bad_ff[k+1] <= bad_ff[k];
            rem_ff[k+1] <= ge ? diff[IDX_W:0] : shifted[IDX_W:0];
            quo_ff[k+1] <= {quo_ff[k][PHASE_BITS-2:0], ge};
         end
      end
   end

   assign out_valid = v_ff[PHASE_BITS];
   assign out_bad   = bad_ff[PHASE_BITS];
   assign out_phase = quo_ff[PHASE_BITS];

endmodule

>>> design/rpg_cordic.sv
// ----------------------------------------------------------------------------
// rpg_cordic: pipelined rotation-mode CORDIC
// One micro-rotation per stage, then clamp and quadrant fold to Q2.30.
// ----------------------------------------------------------------------------
module rpg_cordic #(
   parameter int STAGES = rpg_pkg::CORDIC_STAGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic                         in_tag,
   input  logic [rpg_pkg::ANGLE_W-1:0]  in_angle,
   output logic                         out_valid,
   output logic                         out_tag,
   output rpg_pkg::trig_type            out_trig
);
   import rpg_pkg::*;

   logic                    v_ff [STAGES+1];
   logic                    t_ff [STAGES+1];
   logic [1:0]              q_ff [STAGES+1];
   logic signed [CXY_W-1:0] x_ff [STAGES+1];
   logic signed [CXY_W-1:0] y_ff [STAGES+1];
   logic signed [CZ_W-1:0]  z_ff [STAGES+1];
   logic                    vo_ff;
   logic                    to_ff;
   trig_type                trig_ff;
   trig_type                trig_in;
   logic signed [CXY_W-1:0] cc;
   logic signed [CXY_W-1:0] ss;

   // load stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff[0] <= in_tag;
         q_ff[0] <= in_angle[31:30];
         x_ff[0] <= CORDIC_GAIN_INV;
         y_ff[0] <= '0;
         z_ff[0] <= $signed({3'b000, in_angle[29:0]});
      end
   end

   // micro-rotations
   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      logic signed [CZ_W-1:0] atan_v;
      assign atan_v = $signed({1'b0, ATAN_TURNS[i]});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            v_ff[i+1] <= v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            t_ff[i+1] <= t_ff[i];
            q_ff[i+1] <= q_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_v;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_v;
            end
         end
      end
   end

   // clamp to unit range and fold into the quadrant
   always_comb begin
      cc = x_ff[STAGES];
      ss = y_ff[STAGES];
      if (cc > TRIG_ONE_X) cc = TRIG_ONE_X;
      if (cc < -TRIG_ONE_X) cc = -TRIG_ONE_X;
      if (ss > TRIG_ONE_X) ss = TRIG_ONE_X;
      if (ss < -TRIG_ONE_X) ss = -TRIG_ONE_X;
      case (q_ff[STAGES])
         QUAD_I: begin
            trig_in.cos_v = cc[TRIG_W-1:0];
            trig_in.sin_v = ss[TRIG_W-1:0];
         end
         QUAD_II: begin
            trig_in.cos_v = -ss[TRIG_W-1:0];
            trig_in.sin_v = cc[TRIG_W-1:0];
         end
         QUAD_III: begin
            trig_in.cos_v = -cc[TRIG_W-1:0];
            trig_in.sin_v = -ss[TRIG_W-1:0];
         end
         default: begin
            trig_in.cos_v = ss[TRIG_W-1:0];
            trig_in.sin_v = -cc[TRIG_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (advance) begin
         vo_ff <= v_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         to_ff   <= t_ff[STAGES];
         trig_ff <= trig_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_tag   = to_ff;
   assign out_trig  = trig_ff;

   // folded values stay within the unit range
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_trig.cos_v <= TRIG_ONE) && (out_trig.cos_v >= -TRIG_ONE))
      else $error("cosine out of unit range");
   a_sin_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_trig.sin_v <= TRIG_ONE) && (out_trig.sin_v >= -TRIG_ONE))
      else $error("sine out of unit range");

endmodule

>>> design/rpg_scale.sv
// ----------------------------------------------------------------------------
// rpg_scale: radius scaling and mode selection
// Two multiply stages, each followed by rounding, then the output register.
// ----------------------------------------------------------------------------
module rpg_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic                              in_bad,
   input  rpg_pkg::trig_type                 main_trig,
   input  rpg_pkg::trig_type                 wave_trig,
   input  rpg_pkg::cfg_type                  cfg,
   output logic                              out_valid,
   output logic                              out_bad,
   output logic signed [rpg_pkg::XY_W-1:0]   x_pos,
   output logic signed [rpg_pkg::XY_W-1:0]   y_pos,
   output logic signed [rpg_pkg::Z_W-1:0]    z_pos
);
   import rpg_pkg::*;

   logic signed [RAD_W:0] big;
   logic signed [RAD_W:0] sml;

   // stage a: radius products
   logic                     a_v_ff, a_bad_ff;
   logic signed [56:0]       a_sc2_ff, a_ss2_ff, a_bc1_ff, a_bs1_ff;
   trig_type                 a_trig_ff;
   // stage b: rounded terms and spiral radius
   logic                     b_v_ff, b_bad_ff;
   logic signed [26:0]       b_q_ff, b_zs_ff, b_xb_ff, b_yb_ff;
   trig_type                 b_trig_ff;
   logic signed [63:0]       r_sc2, r_ss2, r_bc1, r_bs1;
   // stage c: spiral products
   logic                     c_v_ff, c_bad_ff;
   logic signed [58:0]       c_qc_ff, c_qs_ff;
   logic signed [26:0]       c_zs_ff, c_xb_ff, c_yb_ff;
   // output stage
   logic                     o_v_ff, o_bad_ff;
   logic signed [XY_W-1:0]   o_x_ff, o_y_ff, x_in, y_in;
   logic signed [Z_W-1:0]    o_z_ff, z_in;
   logic signed [63:0]       r_qc, r_qs, n_qs;

   assign big = $signed({1'b0, cfg.main_radius});
   assign sml = $signed({1'b0, cfg.minor_radius});

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         o_v_ff <= c_v_ff;
      end
   end

   // stage a
   always_ff @(posedge clock) begin
      if (advance) begin
         a_bad_ff  <= in_bad;
         a_sc2_ff  <= sml * wave_trig.cos_v;
         a_ss2_ff  <= sml * wave_trig.sin_v;
         a_bc1_ff  <= big * main_trig.cos_v;
         a_bs1_ff  <= big * main_trig.sin_v;
         a_trig_ff <= main_trig;
      end
   end

   // stage b
   always_comb begin
      r_sc2 = round_q30(64'(a_sc2_ff));
      r_ss2 = round_q30(64'(a_ss2_ff));
      r_bc1 = round_q30(64'(a_bc1_ff));
      r_bs1 = round_q30(64'(a_bs1_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_bad_ff  <= a_bad_ff;
         b_q_ff    <= 27'(big) + r_sc2[26:0];
         b_zs_ff   <= r_ss2[26:0];
         b_xb_ff   <= r_bc1[26:0];
         b_yb_ff   <= r_bs1[26:0];
         b_trig_ff <= a_trig_ff;
      end
   end

   // stage c
   always_ff @(posedge clock) begin
      if (advance) begin
         c_bad_ff <= b_bad_ff;
         c_qc_ff  <= b_q_ff * b_trig_ff.cos_v;
         c_qs_ff  <= b_q_ff * b_trig_ff.sin_v;
         c_zs_ff  <= b_zs_ff;
         c_xb_ff  <= b_xb_ff;
         c_yb_ff  <= b_yb_ff;
      end
   end

   // output selection by mode, zeros for a bad index
   always_comb begin
      r_qc = round_q30(64'(c_qc_ff));
      r_qs = round_q30(64'(c_qs_ff));
      n_qs = -r_qs;
      if (cfg.mode == MODE_SPIRAL) begin
         x_in = r_qc[XY_W-1:0];
         y_in = n_qs[XY_W-1:0];
         z_in = c_zs_ff[Z_W-1:0];
      end else begin
         x_in = c_xb_ff[XY_W-1:0];
         y_in = c_yb_ff[XY_W-1:0];
         z_in = (cfg.mode == MODE_SINE) ? c_zs_ff[Z_W-1:0] : '0;
      end
      if (c_bad_ff) begin
         x_in = '0;
         y_in = '0;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_bad_ff <= c_bad_ff;
         o_x_ff   <= x_in;
         o_y_ff   <= y_in;
         o_z_ff   <= z_in;
      end
   end

   assign out_valid = o_v_ff;
   assign out_bad   = o_bad_ff;
   assign x_pos     = o_x_ff;
   assign y_pos     = o_y_ff;
   assign z_pos     = o_z_ff;

endmodule

>>> design/parametric_ring_point_generator.sv
// Path from accepted index to result: divider, one wave multiply, CORDIC and
// four scale stages.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or its item is taken, so a stall only freezes it.
// Reset: synchronous, clears all valid bits and loads the register defaults
// (circle mode, 100 nodes, radius 1.0, frequency 10, minor radius 0.5).
// ----------------------------------------------------------------------------
// parametric_ring_point_generator: 3-D point on a ring for a node index
// Phase by pipelined division, sine and cosine by two CORDIC pipelines.
// ----------------------------------------------------------------------------
module parametric_ring_point_generator #(
   parameter int PHASE_BITS    = rpg_pkg::PHASE_BITS_DEF,
   parameter int CORDIC_STAGES = rpg_pkg::CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // node_index [15:0]
   input  logic [15:0]                   req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // x_pos [25:0], y_pos [51:26], z_pos [76:52], zero [79:77]
   output logic [79:0]                   rsp_tdata,
   // bad_index [0]
   output logic [0:0]                    rsp_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_wen,
   input  logic [rpg_pkg::CSR_A_W-1:0]   csr_addr,
   input  logic [rpg_pkg::RAD_W-1:0]     csr_wdata
);
   import rpg_pkg::*;

   cfg_type               cfg_ff;
   logic                  advance;
   logic                  d_valid, d_bad;
   logic [PHASE_BITS-1:0] d_phase;
   logic                  w_v_ff, w_bad_ff;
   logic [PHASE_BITS-1:0] w_ph_ff, w_wph_ff;
   logic [PHASE_BITS+FREQ_W-1:0] w_prod;
   logic [ANGLE_W-1:0]    ang_main, ang_wave;
   logic                  c_valid, c_bad;
   trig_type              main_trig, wave_trig;
   logic                  s_valid, s_bad;
   logic signed [XY_W-1:0] x_pos, y_pos;
   logic signed [Z_W-1:0] z_pos;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_CIRCLE;
         cfg_ff.node_count     <= 16'd100;
         cfg_ff.main_radius    <= 24'd65536;
         cfg_ff.wave_frequency <= 16'd10;
         cfg_ff.minor_radius   <= 24'd32768;
      end else if (csr_wen) begin
         case (csr_addr)
            REG_MODE:       cfg_ff.mode           <= csr_wdata[1:0];
            REG_NODE_COUNT: cfg_ff.node_count     <= csr_wdata[IDX_W-1:0];
            REG_MAIN_RAD:   cfg_ff.main_radius    <= csr_wdata;
            REG_WAVE_FREQ:  cfg_ff.wave_frequency <= csr_wdata[FREQ_W-1:0];
            REG_MINOR_RAD:  cfg_ff.minor_radius   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global pipeline advance
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // phase
   rpg_div #(.PHASE_BITS(PHASE_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .in_index   (req_tdata),
      .node_count (cfg_ff.node_count),
      .out_valid  (d_valid),
      .out_bad    (d_bad),
      .out_phase  (d_phase)
   );

   // wave phase, modulo one turn
   assign w_prod = d_phase * cfg_ff.wave_frequency;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_v_ff <= 1'b0;
      end else if (advance) begin
         w_v_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         w_bad_ff <= d_bad;
         w_ph_ff  <= d_phase;
         w_wph_ff <= w_prod[PHASE_BITS-1:0];
      end
   end

   // align phases to a 32-bit turn fraction
   if (PHASE_BITS >= ANGLE_W) begin : g_ang_top
      assign ang_main = w_ph_ff[PHASE_BITS-1 -: ANGLE_W];
      assign ang_wave = w_wph_ff[PHASE_BITS-1 -: ANGLE_W];
   end else begin : g_ang_pad
      assign ang_main = {w_ph_ff, {(ANGLE_W-PHASE_BITS){1'b0}}};
      assign ang_wave = {w_wph_ff, {(ANGLE_W-PHASE_BITS){1'b0}}};
   end

   // sine and cosine of both angles
   rpg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_main (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (w_v_ff),
      .in_tag    (w_bad_ff),
      .in_angle  (ang_main),
      .out_valid (c_valid),
      .out_tag   (c_bad),
      .out_trig  (main_trig)
   );

   rpg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_wave (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (w_v_ff),
      .in_tag    (1'b0),
      .in_angle  (ang_wave),
      .out_valid (),
      .out_tag   (),
      .out_trig  (wave_trig)
   );

   // scaling, selection and output register
   rpg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (c_valid),
      .in_bad    (c_bad),
      .main_trig (main_trig),
      .wave_trig (wave_trig),
      .cfg       (cfg_ff),
      .out_valid (s_valid),
      .out_bad   (s_bad),
      .x_pos     (x_pos),
      .y_pos     (y_pos),
      .z_pos     (z_pos)
   );

   assign rsp_tvalid = s_valid;
   assign rsp_tuser  = s_bad;
   assign rsp_tdata  = {3'b000, z_pos, y_pos, x_pos};

   // an out-of-range index gives a zero point
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("bad index item carries nonzero coordinates");

endmodule
